>>> hdl/gpab_pkg.sv
// ----------------------------------------------------------------------------
// gpab_pkg
// shared types, constants and helper functions of the glyph pixel blender
// ----------------------------------------------------------------------------
`default_nettype none

package gpab_pkg;

   localparam int GLYPH_WIDTH   = 8;
   localparam int GLYPH_HEIGHT  = 16;

   localparam int ROW_BITS_W    = 8;
   localparam int GLYPH_ROW_W   = 4;
   localparam int GLYPH_COL_W   = 3;
   localparam int CHAR_X_W      = 12;
   localparam int PIXEL_W       = 32;
   localparam int FRAME_DIM_W   = 13;
   localparam int COUNT_W       = 4;
   localparam int CHAN_W        = 8;

   localparam int REQ_FIELDS_W  = 3 * ROW_BITS_W + GLYPH_ROW_W + GLYPH_COL_W
                                  + CHAR_X_W + PIXEL_W;
   localparam int REQ_TDATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W   = PIXEL_W;
   localparam int CSR_INDEX_W   = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [FRAME_DIM_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [FRAME_DIM_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam logic [PIXEL_W-1:0] WHITE_ARGB   = 32'hFFFF_FFFF;
   localparam logic [CHAN_W-1:0]  OPAQUE_ALPHA = 8'hFF;
   localparam logic [COUNT_W-1:0] FULL_COUNT   = 4'd9;

   typedef struct packed {
      logic [PIXEL_W-1:0]     dest_pixel;
      logic [CHAR_X_W-1:0]    char_x;
      logic [GLYPH_COL_W-1:0] glyph_col;
      logic [GLYPH_ROW_W-1:0] glyph_row;
      logic [ROW_BITS_W-1:0]  bits_below;
      logic [ROW_BITS_W-1:0]  bits_here;
      logic [ROW_BITS_W-1:0]  bits_above;
   } req_beat_type;

   // set bits of one glyph row in columns col-1..col+1, bit 7 is column 0
   function automatic logic [1:0] row_count(input logic [ROW_BITS_W-1:0] bits,
                                            input logic [GLYPH_COL_W-1:0] col);
      logic [ROW_BITS_W+1:0] ext;
      logic [ROW_BITS_W+1:0] shifted;
      ext     = {1'b0, bits, 1'b0};
      shifted = ext >> (3'd7 - col);
      return {1'b0, shifted[0]} + {1'b0, shifted[1]} + {1'b0, shifted[2]};
   endfunction

   // coverage alpha = (n*255+4)/9
   function automatic logic [CHAN_W-1:0] count_alpha(input logic [COUNT_W-1:0] n);
      logic [CHAN_W-1:0] a;
      case (n)
         4'd0:    a = 8'd0;
         4'd1:    a = 8'd28;
         4'd2:    a = 8'd57;
         4'd3:    a = 8'd85;
         4'd4:    a = 8'd113;
         4'd5:    a = 8'd142;
         4'd6:    a = 8'd170;
         4'd7:    a = 8'd198;
         4'd8:    a = 8'd227;
         default: a = 8'd255;
      endcase
      return a;
   endfunction

   // white over d: a + floor(d*(255-a)/255), division by 255 done with adds
   function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] d,
                                                      input logic [CHAN_W-1:0] a);
      logic [2*CHAN_W-1:0] m;
      logic [2*CHAN_W:0]   t;
      logic [CHAN_W-1:0]   q;
      m = {8'd0, d} * {8'd0, 8'd255 - a};
      t = {1'b0, m} + 17'd1 + {9'd0, m[2*CHAN_W-1:CHAN_W]};
      q = t[2*CHAN_W-1:CHAN_W];
      return a + q;
   endfunction

endpackage

`default_nettype wire

>>> hdl/glyph_pixel_antialias_blend_core.sv
// ----------------------------------------------------------------------------
// glyph_pixel_antialias_blend_core
// 3x3 box-filter coverage of a bitmap glyph pixel, blended white over dest
// ----------------------------------------------------------------------------
// One request beat carries the three glyph rows around a pixel, its place in
// the glyph, the glyph's x origin and the destination ARGB pixel; one
// response beat comes back for each request, in order. Set bits in the 3x3
// neighborhood (rows outside the glyph and columns outside 0..7 ignored) give
// a coverage alpha of (n*255+4)/9, and opaque white is laid over the
// destination with src-over, alpha byte forced to 0xFF. rsp_tuser is the
// write enable: low when the pixel is clipped by frame_width/frame_height or
// has no coverage, and then rsp_tdata is the destination unchanged. The path
// is an input register, one level of counting/blend logic and a result
// register: one beat per cycle sustained while rsp_tready stays high, and a
// new request is taken while a finished response waits if the input register
// is empty. The user must write frame_width and frame_height through the csr
// port only while no beat is in flight; the core does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_pixel_antialias_blend_core
   import gpab_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   // bits_above[7:0], bits_here[15:8], bits_below[23:16], glyph_row[27:24],
   // glyph_col[30:28], char_x[42:31], dest_pixel[74:43], zero pad [79:75]
   input  wire logic [REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,

   // pixel_out[31:0]
   output logic [RSP_TDATA_W-1:0]        rsp_tdata,
   // write_enable[0]
   output logic                          rsp_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,

   input  wire logic                     csr_we,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [FRAME_DIM_W-1:0]   csr_wdata
);

   // configuration registers
   logic [FRAME_DIM_W-1:0] frame_width_ff;
   logic [FRAME_DIM_W-1:0] frame_height_ff;

   // input stage
   logic         in_valid_ff;
   req_beat_type in_ff;

   // result stage
   logic               rsp_valid_ff;
   logic               rsp_we_ff;
   logic [PIXEL_W-1:0] rsp_pixel_ff;
   logic               rsp_we_in;
   logic [PIXEL_W-1:0] rsp_pixel_in;

   logic advance;

   // pipeline moves when the result slot is free or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_ff <= req_beat_type'(req_tdata[REQ_FIELDS_W-1:0]);
      end
   end

   // ---------------------------------------------------------------- compute
   logic [FRAME_DIM_W-1:0] pix_x;
   logic                   clipped;
   logic                   above_ok;
   logic                   here_ok;
   logic                   below_ok;
   logic [GLYPH_ROW_W:0]   row_next;
   logic [1:0]             cnt_above;
   logic [1:0]             cnt_here;
   logic [1:0]             cnt_below;
   logic [COUNT_W-1:0]     count;
   logic [CHAN_W-1:0]      alpha;
   logic [CHAN_W-1:0]      mix_r;
   logic [CHAN_W-1:0]      mix_g;
   logic [CHAN_W-1:0]      mix_b;

   always_comb begin
      pix_x    = {1'b0, in_ff.char_x} + FRAME_DIM_W'(in_ff.glyph_col);
      clipped  = (pix_x >= frame_width_ff) ||
                 (FRAME_DIM_W'(in_ff.glyph_row) >= frame_height_ff);

      // rows outside the glyph add nothing
      row_next = {1'b0, in_ff.glyph_row} + 5'd1;
      here_ok  = 32'(in_ff.glyph_row) < GLYPH_HEIGHT;
      above_ok = (in_ff.glyph_row != '0) &&
                 (32'(in_ff.glyph_row) <= GLYPH_HEIGHT);
      below_ok = 32'(row_next) < GLYPH_HEIGHT;

      cnt_above = above_ok ? row_count(in_ff.bits_above, in_ff.glyph_col) : 2'd0;
      cnt_here  = here_ok  ? row_count(in_ff.bits_here,  in_ff.glyph_col) : 2'd0;
      cnt_below = below_ok ? row_count(in_ff.bits_below, in_ff.glyph_col) : 2'd0;
      count     = {2'b00, cnt_above} + {2'b00, cnt_here} + {2'b00, cnt_below};

      alpha = count_alpha(count);
      mix_r = mix_channel(in_ff.dest_pixel[23:16], alpha);
      mix_g = mix_channel(in_ff.dest_pixel[15:8],  alpha);
      mix_b = mix_channel(in_ff.dest_pixel[7:0],   alpha);

      rsp_we_in = !clipped && (count != '0);
      if (!rsp_we_in) begin
         rsp_pixel_in = in_ff.dest_pixel;
      end else if (count == FULL_COUNT) begin
         rsp_pixel_in = WHITE_ARGB;
      end else begin
         rsp_pixel_in = {OPAQUE_ALPHA, mix_r, mix_g, mix_b};
      end
   end

   // ----------------------------------------------------------- result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
      if (advance && in_valid_ff) begin
         rsp_we_ff    <= rsp_we_in;
         rsp_pixel_ff <= rsp_pixel_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_we_ff;
   assign rsp_tdata  = rsp_pixel_ff;

endmodule

`default_nettype wire

>>> tb/glyph_blend_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_blend_checker
// watches the blend core's channels, predicts each pixel and compares
// ----------------------------------------------------------------------------
// Every accepted request beat is turned into the expected write enable and
// blended pixel under the frame size seen on the csr port at that time. Each
// response beat is compared with the oldest expected pixel.
// ----------------------------------------------------------------------------

module glyph_blend_checker
   import gpab_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,

   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                   rsp_tuser,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,

   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [FRAME_DIM_W-1:0] csr_wdata,

   output int                          failures,
   output int                          pending
);

   typedef struct packed {
      logic               write_enable;
      logic [PIXEL_W-1:0] pixel;
   } blended_pixel_type;

   blended_pixel_type      expected_pixels[$];
   logic [FRAME_DIM_W-1:0] frame_width;
   logic [FRAME_DIM_W-1:0] frame_height;

   // set bits of one glyph row in columns col-1..col+1
   function automatic int row_hits(input logic [ROW_BITS_W-1:0] bits, input int col);
      int n;
      int c;
      n = 0;
      for (c = col - 1; c <= col + 1; c++) begin
         if (c >= 0 && c < GLYPH_WIDTH && bits[GLYPH_WIDTH-1-c])
            n++;
      end
      return n;
   endfunction

   // box-filter coverage, then opaque white laid over the destination
   function automatic blended_pixel_type blend_white_over(input req_beat_type b,
                                                          input int width,
                                                          input int height);
      blended_pixel_type      res;
      logic [ROW_BITS_W-1:0]  rows [3];
      int                     x;
      int                     row;
      int                     rr;
      int                     dr;
      int                     n;
      int unsigned            a;
      int unsigned            d;
      int                     k;
      rows[0] = b.bits_above;
      rows[1] = b.bits_here;
      rows[2] = b.bits_below;
      x   = int'(b.char_x) + int'(b.glyph_col);
      row = int'(b.glyph_row);
      res.write_enable = 1'b0;
      res.pixel        = b.dest_pixel;
      if (x >= width || row >= height)
         return res;
      n = 0;
      for (dr = -1; dr <= 1; dr++) begin
         rr = row + dr;
         if (rr >= 0 && rr < GLYPH_HEIGHT)
            n += row_hits(rows[dr+1], int'(b.glyph_col));
      end
      if (n == 0)
         return res;
      a = (n * 255 + 4) / 9;
      res.write_enable = 1'b1;
      if (a >= 255) begin
         res.pixel = WHITE_ARGB;
      end else begin
         for (k = 0; k < 3; k++) begin
            d = (b.dest_pixel >> (8 * k)) & 32'hFF;
            res.pixel[8*k +: 8] = 8'((255 * a + d * (255 - a)) / 255);
         end
         res.pixel[31:24] = OPAQUE_ALPHA;
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      blended_pixel_type want;
      req_beat_type      beat;
      int                bad;
      bad = 0;
      if (reset) begin
         frame_width  <= FRAME_WIDTH_RESET;
         frame_height <= FRAME_HEIGHT_RESET;
         expected_pixels.delete();
         failures     <= 0;
         pending      <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_FRAME_WIDTH)
               frame_width <= csr_wdata;
            else if (csr_index == CSR_FRAME_HEIGHT)
               frame_height <= csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected response beat, got we %0b pixel %08h",
                        $time, rsp_tuser, rsp_tdata);
               bad = 1;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tuser !== want.write_enable) begin
                  $display("%0t: write_enable expected %0b got %0b",
                           $time, want.write_enable, rsp_tuser);
                  bad = 1;
               end
               if (rsp_tdata !== want.pixel) begin
                  $display("%0t: pixel_out expected %08h got %08h",
                           $time, want.pixel, rsp_tdata);
                  bad = 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            beat = req_beat_type'(req_tdata[REQ_FIELDS_W-1:0]);
            expected_pixels.push_back(blend_white_over(beat, int'(frame_width),
                                                       int'(frame_height)));
         end
         failures <= failures + bad;
         pending  <= expected_pixels.size();
      end
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the glyph pixel anti-alias blend core
// ----------------------------------------------------------------------------
// Drives request beats with random gaps and random response stalls, walks
// through several frame sizes (smallest, largest, zero and random ones) set
// while the core is idle, and leaves all checking to glyph_blend_checker.
// ----------------------------------------------------------------------------

module tb
   import gpab_pkg::*;
();

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_BEATS = 200;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;

   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;

   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_FRAME_WIDTH;
   logic [FRAME_DIM_W-1:0] csr_wdata = '0;

   int                     failures;
   int                     pending;
   int                     cycle_count = 0;

   // both sides run without gaps while this is set
   bit                     burst = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   glyph_pixel_antialias_blend_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   glyph_blend_checker blend_check (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .failures   (failures),
      .pending    (pending)
   );

   // hard stop in case a beat never comes back
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // idle gap before a beat, drawn at random, none during a burst
   function automatic int idle_cycles();
      return burst ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic req_beat_type pixel_beat(input logic [7:0] above,
                                                input logic [7:0] here,
                                                input logic [7:0] below,
                                                input int row, input int col,
                                                input int cx,
                                                input logic [31:0] dest);
      req_beat_type b;
      b.bits_above = above;
      b.bits_here  = here;
      b.bits_below = below;
      b.glyph_row  = GLYPH_ROW_W'(row);
      b.glyph_col  = GLYPH_COL_W'(col);
      b.char_x     = CHAR_X_W'(cx);
      b.dest_pixel = dest;
      return b;
   endfunction

   // sparse, dense or plain random glyph row
   function automatic logic [7:0] glyph_bits();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'($urandom() & $urandom());
         3:       return 8'($urandom() | $urandom());
         default: return 8'($urandom());
      endcase
   endfunction

   // half the beats land near the right frame edge so clipping gets exercised
   function automatic req_beat_type random_pixel(input int width);
      int cx;
      if ($urandom_range(0, 1))
         cx = $urandom_range(0, 4095);
      else
         cx = width - 8 + $urandom_range(0, 15);
      if (cx < 0)
         cx = 0;
      if (cx > 4095)
         cx = 4095;
      return pixel_beat(glyph_bits(), glyph_bits(), glyph_bits(),
                        $urandom_range(0, 15), $urandom_range(0, 7), cx, $urandom());
   endfunction

   // one request beat, held until the core takes it
   task automatic send_pixel(input req_beat_type b);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= REQ_TDATA_W'(b);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // wait for every expected pixel plus pipeline slack
   task automatic wait_drained();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= FRAME_DIM_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending, let the core go idle, then set a new frame size
   task automatic set_frame(input int width, input int height);
      req_tvalid <= 1'b0;
      wait_drained();
      write_reg(CSR_FRAME_WIDTH, width);
      write_reg(CSR_FRAME_HEIGHT, height);
   endtask

   // response side: random stall before each beat
   initial begin : rsp_side
      int stall;
      @(posedge clock);
      forever begin
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : stimulus
      int p;
      int i;
      int w;
      int h;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset frame size 640x480
      // no coverage keeps the destination
      send_pixel(pixel_beat(8'h00, 8'h00, 8'h00, 5, 3, 100, 32'h1234_5678));
      // full coverage gives white
      send_pixel(pixel_beat(8'hFF, 8'hFF, 8'hFF, 5, 3, 100, 32'h0000_0000));
      // top row, left column: row above and column -1 ignored
      send_pixel(pixel_beat(8'hFF, 8'hFF, 8'hFF, 0, 0, 0, 32'h8040_2010));
      // bottom row, right column: row below and column 8 ignored
      send_pixel(pixel_beat(8'hFF, 8'hFF, 8'hFF, 15, 7, 0, 32'hFFFF_FFFF));
      // coverage counts one through eight
      send_pixel(pixel_beat(8'h80, 8'h00, 8'h00, 7, 1, 10, 32'h00FF_00FF));
      send_pixel(pixel_beat(8'h01, 8'h01, 8'h00, 7, 7, 10, 32'hFF00_FF00));
      send_pixel(pixel_beat(8'hE0, 8'h00, 8'h00, 7, 1, 10, 32'h7F7F_7F7F));
      send_pixel(pixel_beat(8'hC0, 8'hC0, 8'h00, 7, 1, 10, 32'hDEAD_BEEF));
      send_pixel(pixel_beat(8'hE0, 8'hC0, 8'h00, 7, 1, 10, 32'h0102_0304));
      send_pixel(pixel_beat(8'hE0, 8'hE0, 8'h00, 7, 1, 10, 32'hA5A5_5A5A));
      send_pixel(pixel_beat(8'hE0, 8'h40, 8'hE0, 7, 1, 10, 32'h00FE_FD01));
      send_pixel(pixel_beat(8'hE0, 8'hA0, 8'hE0, 7, 1, 10, 32'h8000_0080));
      // x clipping at the frame edge and at the top of char_x
      send_pixel(pixel_beat(8'hFF, 8'hFF, 8'hFF, 3, 7, 4095, 32'h1111_1111));
      send_pixel(pixel_beat(8'hFF, 8'h00, 8'h00, 3, 0, 639, 32'h2222_2222));
      send_pixel(pixel_beat(8'hFF, 8'hFF, 8'hFF, 3, 0, 640, 32'h3333_3333));
      send_pixel(pixel_beat(8'hFF, 8'hFF, 8'hFF, 3, 7, 633, 32'h4444_4444));

      // smallest frame: only the origin pixel is written
      set_frame(1, 1);
      send_pixel(pixel_beat(8'hFF, 8'h80, 8'h00, 0, 0, 0, 32'h5555_5555));
      send_pixel(pixel_beat(8'hFF, 8'hFF, 8'hFF, 1, 0, 0, 32'h6666_6666));
      send_pixel(pixel_beat(8'hFF, 8'hFF, 8'hFF, 0, 1, 0, 32'h7777_7777));

      // zero-sized frame clips everything
      set_frame(0, 0);
      send_pixel(pixel_beat(8'hFF, 8'hFF, 8'hFF, 0, 0, 0, 32'h8888_8888));
      send_pixel(pixel_beat(8'hFF, 8'hFF, 8'hFF, 9, 4, 17, 32'h9999_9999));

      // largest frame
      set_frame(4096, 4096);
      send_pixel(pixel_beat(8'hFF, 8'hFF, 8'hFF, 15, 0, 4095, 32'hAAAA_AAAA));
      send_pixel(pixel_beat(8'hFF, 8'hFF, 8'hFF, 15, 1, 4095, 32'hBBBB_BBBB));

      // random phases, each under its own frame size
      for (p = 0; p < 9; p++) begin
         case (p)
            0:       begin w = 4096; h = 4096; end
            1:       begin w = 1;    h = 1;    end
            2:       begin w = 640;  h = 480;  end
            3:       begin w = 4095; h = 16;   end
            default: begin w = $urandom_range(1, 4096); h = $urandom_range(1, 17); end
         endcase
         set_frame(w, h);
         for (i = 0; i < PHASE_BEATS; i++) begin
            if (i % 50 == 0)
               burst = ($urandom_range(0, 3) == 0);
            send_pixel(random_pixel(w));
         end
         burst = 1'b0;
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> glyph_pixel_antialias_blend_core.f
hdl/gpab_pkg.sv
hdl/glyph_pixel_antialias_blend_core.sv
tb/glyph_blend_checker.sv
tb/tb.sv
